// File: hw/rtl/tpt_pkg.sv
// Shared types and constants for the TLB and page-table translator.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package tpt_pkg;

   // Fixed widths of the request and response fields.
   localparam int unsigned PAGE_NUMBER_W = 8;
   localparam int unsigned PAGE_OFFSET_W = 8;
   localparam int unsigned PHYS_ADDR_W   = 16;
   localparam int unsigned STATUS_W      = 2;

   // Number of distinct values an 8-bit request field can carry.
   localparam int unsigned FIELD_VALUES  = 256;

   // Width of the product used to form the physical address.
   localparam int unsigned PRODUCT_W     = 32;

   typedef enum logic [STATUS_W-1:0] {
      ST_TLB_HIT   = 2'd0,
      ST_TABLE_HIT = 2'd1,
      ST_FAULT     = 2'd2
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/tpt_tlb.sv
// Fully associative TLB with FIFO replacement, held in flip-flops.
// Depends on no package; widths come from the parent's parameters.
`default_nettype none

module tpt_tlb #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned TIW   = 8,
   parameter int unsigned FW    = 8
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [TIW-1:0] lookup_page,
   output logic                hit,
   output logic [FW-1:0]       hit_frame,
   input  wire logic           fill_en,
   input  wire logic [TIW-1:0] fill_page,
   input  wire logic [FW-1:0]  fill_frame
);

   localparam int unsigned IW = $clog2(DEPTH);

   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [TIW-1:0]   page_ff  [DEPTH];
   logic [TIW-1:0]   page_in  [DEPTH];
   logic [FW-1:0]    frame_ff [DEPTH];
   logic [FW-1:0]    frame_in [DEPTH];

   logic             any_free;
   logic [IW-1:0]    free_idx;

   // Lowest-numbered matching slot wins.
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (valid_ff[k] && (page_ff[k] == lookup_page)) begin
            hit       = 1'b1;
            hit_frame = frame_ff[k];
         end
      end
   end

   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            any_free = 1'b1;
            free_idx = IW'(k);
         end
      end
   end

   // Fill into the first empty slot, or shift everything up one place and
   // put the new entry at slot 0 when the TLB is full.
   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      frame_in = frame_ff;
      if (fill_en) begin
         if (any_free) begin
            valid_in[free_idx] = 1'b1;
            page_in[free_idx]  = fill_page;
            frame_in[free_idx] = fill_frame;
         end else begin
            for (int k = DEPTH - 1; k > 0; k--) begin
               valid_in[k] = valid_ff[k-1];
               page_in[k]  = page_ff[k-1];
               frame_in[k] = frame_ff[k-1];
            end
            valid_in[0] = 1'b1;
            page_in[0]  = fill_page;
            frame_in[0] = fill_frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      frame_ff <= frame_in;
   end

   a_fill_sets_slot0 : assert property (@(posedge clock) disable iff (reset)
      fill_en |=> valid_ff[0])
      else $error("TLB slot 0 not valid after a fill");

   a_no_fill_on_hit : assert property (@(posedge clock) disable iff (reset)
      fill_en |-> !hit)
      else $error("TLB fill requested for a page that already hits");

endmodule

`default_nettype wire

// File: hw/rtl/tpt_table.sv
// Page table: frame memory with registered read, valid flags in flip-flops,
// write bypass and the free-frame allocator. Depends on no package.
`default_nettype none

module tpt_table #(
   parameter int unsigned ENTRIES     = 256,
   parameter int unsigned TIW         = 8,
   parameter int unsigned FW          = 8,
   parameter int unsigned FRAME_COUNT = 256
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [TIW-1:0] rd_page,
   input  wire logic [TIW-1:0] lookup_page,
   input  wire logic           wr_en,
   output logic                entry_valid,
   output logic [FW-1:0]       entry_frame,
   output logic [FW-1:0]       alloc_frame
);

   localparam int unsigned NFW = $clog2(FRAME_COUNT + 1);

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [FW-1:0]      frame_mem_ff [ENTRIES];
   logic [FW-1:0]      rd_data_ff;
   logic               byp_ff, byp_in;
   logic [FW-1:0]      byp_frame_ff;
   logic [NFW-1:0]     next_free_ff, next_free_in;
   logic               frames_gone;

   assign frames_gone = (next_free_ff >= NFW'(FRAME_COUNT));
   assign alloc_frame = frames_gone ? FW'(FRAME_COUNT - 1) : next_free_ff[FW-1:0];

   always_comb begin
      valid_in     = valid_ff;
      next_free_in = next_free_ff;
      if (wr_en) begin
         valid_in[lookup_page] = 1'b1;
         if (!frames_gone) begin
            next_free_in = next_free_ff + NFW'(1);
         end
      end
   end

   // The read for the next lookup happens at the same edge as this write,
   // so a write to the same page is forwarded around the memory.
   assign byp_in      = wr_en && (rd_page == lookup_page);
   assign entry_valid = valid_ff[lookup_page];
   assign entry_frame = byp_ff ? byp_frame_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_free_ff <= '0;
         byp_ff       <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         next_free_ff <= next_free_in;
         byp_ff       <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[lookup_page] <= alloc_frame;
      end
      rd_data_ff   <= frame_mem_ff[rd_page];
      byp_frame_ff <= alloc_frame;
   end

   a_write_sets_valid : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(lookup_page)])
      else $error("page table entry not valid after a fault");

   a_alloc_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> next_free_ff >= $past(next_free_ff))
      else $error("free-frame counter went backwards");

endmodule

`default_nettype wire

// File: hw/rtl/tlb_page_table_translator.sv
// Top level of the TLB and page-table address translator.
// Depends on tpt_pkg, tpt_tlb and tpt_table.
`default_nettype none

// A virtual page number and offset are taken when start is high and busy is
// low; busy never rises, so one request beat can be taken on every clock.
// Each request produces exactly one response beat, shown on the rsp_ ports
// with rsp_valid high for a single cycle, where the beat is taken, once the
// request has passed the request and response registers in that order:
// the request edge loads the request register and starts the page-table
// memory read, the next edge loads the response register and updates the TLB,
// the page-table flags and the free-frame counter. The receiver cannot hold
// responses off, so the sustained rate is one translation per cycle. The
// status is a TLB hit, a page-table hit (the mapping is copied into the TLB,
// first empty slot or FIFO shift into slot 0) or a page fault, which takes
// the next free frame, saturating at the last frame, and leaves the TLB
// alone. Valid flags clear at reset; there is no memory clearing pass.
module tlb_page_table_translator #(
   parameter int unsigned TLB_DEPTH   = 16,
   parameter int unsigned PAGE_COUNT  = 256,
   parameter int unsigned FRAME_COUNT = 256,
   parameter int unsigned PAGE_BYTES  = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [tpt_pkg::PAGE_NUMBER_W-1:0]  req_page_number,
   input  wire logic [tpt_pkg::PAGE_OFFSET_W-1:0]  req_page_offset,
   output logic                                    rsp_valid,
   output logic [tpt_pkg::PHYS_ADDR_W-1:0]         rsp_physical_address,
   output logic [tpt_pkg::STATUS_W-1:0]            rsp_status
);

   // Only the first FIELD_VALUES pages are reachable from an 8-bit page number.
   localparam int unsigned TBL_ENTRIES = (PAGE_COUNT < tpt_pkg::FIELD_VALUES) ?
                                         PAGE_COUNT : tpt_pkg::FIELD_VALUES;
   localparam int unsigned TIW = $clog2(TBL_ENTRIES);
   localparam int unsigned FW  = $clog2(FRAME_COUNT);
   localparam int unsigned OW  = tpt_pkg::PAGE_OFFSET_W;
   localparam int unsigned PW  = tpt_pkg::PRODUCT_W;

   logic                 accept;

   // Constant tables that reduce the page number and offset to their ranges.
   logic [TIW-1:0]       page_lut [tpt_pkg::FIELD_VALUES];
   logic [OW-1:0]        off_lut  [tpt_pkg::FIELD_VALUES];
   logic [TIW-1:0]       req_page;

   // Request register.
   logic                 s1_valid_ff;
   logic [TIW-1:0]       s1_page_ff;
   logic [OW-1:0]        s1_off_ff;

   logic                 tlb_hit;
   logic [FW-1:0]        tlb_frame;
   logic                 tbl_valid;
   logic [FW-1:0]        tbl_frame;
   logic [FW-1:0]        alloc_frame;
   logic                 fill_en;
   logic                 fault_en;
   logic [FW-1:0]        frame;
   tpt_pkg::status_type  status;
   logic [PW-1:0]        addr_wide;

   // Response register.
   logic                                 rsp_valid_ff;
   logic [tpt_pkg::PHYS_ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   tpt_pkg::status_type                  rsp_status_ff;

   for (genvar g = 0; g < tpt_pkg::FIELD_VALUES; g++) begin : g_lut
      assign page_lut[g] = TIW'(g % TBL_ENTRIES);
      assign off_lut[g]  = OW'(g % PAGE_BYTES);
   end

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign req_page = page_lut[req_page_number];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_page_ff <= req_page;
      s1_off_ff  <= off_lut[req_page_offset];
   end

   tpt_tlb #(
      .DEPTH (TLB_DEPTH),
      .TIW   (TIW),
      .FW    (FW)
   ) u_tlb (
      .clock       (clock),
      .reset       (reset),
      .lookup_page (s1_page_ff),
      .hit         (tlb_hit),
      .hit_frame   (tlb_frame),
      .fill_en     (fill_en),
      .fill_page   (s1_page_ff),
      .fill_frame  (tbl_frame)
   );

   // The memory read is issued for the incoming request every cycle; its
   // data is used only when that request was actually taken.
   tpt_table #(
      .ENTRIES     (TBL_ENTRIES),
      .TIW         (TIW),
      .FW          (FW),
      .FRAME_COUNT (FRAME_COUNT)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .rd_page     (req_page),
      .lookup_page (s1_page_ff),
      .wr_en       (fault_en),
      .entry_valid (tbl_valid),
      .entry_frame (tbl_frame),
      .alloc_frame (alloc_frame)
   );

   // A TLB hit wins; otherwise a valid page-table entry is used and copied
   // into the TLB; otherwise the page faults and takes a fresh frame.
   always_comb begin
      if (tlb_hit) begin
         frame  = tlb_frame;
         status = tpt_pkg::ST_TLB_HIT;
      end else if (tbl_valid) begin
         frame  = tbl_frame;
         status = tpt_pkg::ST_TABLE_HIT;
      end else begin
         frame  = alloc_frame;
         status = tpt_pkg::ST_FAULT;
      end
   end

   assign fill_en  = s1_valid_ff && !tlb_hit && tbl_valid;
   assign fault_en = s1_valid_ff && !tlb_hit && !tbl_valid;

   // The address keeps only its low bits, as the response field is fixed.
   assign addr_wide   = PW'(frame) * PW'(PAGE_BYTES) + PW'(s1_off_ff);
   assign rsp_addr_in = addr_wide[tpt_pkg::PHYS_ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= status;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_status           = rsp_status_ff;

   // Every response beat comes from an earlier request beat, carried through the request and response registers.
   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("response beat without a matching request beat");

   // The TLB is only filled from the page table, and page-table entries are
   // never dropped, so a TLB hit always has a valid page-table entry behind it.
   a_tlb_backed_by_table : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && tlb_hit) |-> tbl_valid)
      else $error("TLB holds a page that the page table does not map");

endmodule

`default_nettype wire
